// ===== src/pih_pkg.sv =====
// package for the point-in-hexahedron test unit
// holds face tables, widths and controller/datapath command types; no dependencies
package pih_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_FACES      = 6;
    localparam int NUM_CORNERS    = 8;
    localparam int FACE_W         = 3;
    localparam int CORNER_W       = 3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    function automatic logic [CORNER_W-1:0] face_core(input logic [FACE_W-1:0] f);
        logic [CORNER_W-1:0] r;
        unique case (f)
            3'd0: r = 3'd0;
            3'd1: r = 3'd1;
            3'd2: r = 3'd0;
            3'd3: r = 3'd4;
            3'd4: r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CORNER_W-1:0] face_a(input logic [FACE_W-1:0] f);
        logic [CORNER_W-1:0] r;
        unique case (f)
            3'd0: r = 3'd4;
            3'd1: r = 3'd3;
            3'd2: r = 3'd2;
            3'd3: r = 3'd5;
            3'd4: r = 3'd6;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [CORNER_W-1:0] face_b(input logic [FACE_W-1:0] f);
        logic [CORNER_W-1:0] r;
        unique case (f)
            3'd0: r = 3'd2;
            3'd1: r = 3'd5;
            3'd2: r = 3'd1;
            3'd3: r = 3'd6;
            3'd4: r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    // controller to datapath
    typedef struct packed {
        logic                  load_vertex;  // write held vertex into store
        logic                  latch_point;  // capture test point
        logic                  norm_step;    // compute normal of face
        logic                  dot_step;     // compute dot product of face
        logic                  clear_flag;   // start a new test
        logic                  load_result;  // copy the flag into the output register
        logic [FACE_W-1:0]     face;
    } pih_cmd_t;
endpackage

// ===== src/point_in_hexahedron_test_unit.sv =====
// top level of the point-in-hexahedron test unit
// joins pih_ctrl and pih_dp; depends on pih_pkg
//
// s_ channel carries load and test items; m_ channel carries one result per test
// a load (kind 0) writes one corner and rebuilds the six face normals, one face per
//   cycle through the shared cross-product unit: no result, next item taken
//   after the last face normal is rebuilt
// a test (kind 1) runs six dot products, one face per cycle, then a tail step for the last
//   sign and an output step that fills the output register; the result is offered from there,
//   and the next item is taken after the output step
// s_tready is high only while idle, so items are taken one at a time
// when the receiver stalls the result waits in the m_ output register; further
// items are still taken, and a later test holds in its last step until the
// waiting result is taken
// reset (aresetn low, synchronous) clears corners and normals to zero, so a test
// before any load reports inside
module point_in_hexahedron_test_unit #(
    parameter int COORD_BITS = pih_pkg::COORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // vertex_index[2:0], coord_x, coord_y, coord_z, zero pad
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // inside_res, zero pad
);
    import pih_pkg::*;

    pih_cmd_t cmd;
    logic     inside_bit;

    pih_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .kind(s_tuser),
        .m_tvalid, .m_tready, .cmd
    );

    pih_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .aresetn, .cmd,
        .vertex_index(s_tdata[2:0]),
        .coord_x(s_tdata[3 +: COORD_BITS]),
        .coord_y(s_tdata[19 +: COORD_BITS]),
        .coord_z(s_tdata[35 +: COORD_BITS]),
        .inside_res(inside_bit)
    );

    assign m_tdata = {7'd0, inside_bit};
endmodule

// ===== src/pih_ctrl.sv =====
// controller for the point-in-hexahedron test unit
// sequences six face steps per load or test; depends on pih_pkg
module pih_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             kind,
    output logic             m_tvalid,
    input  logic             m_tready,
    output pih_pkg::pih_cmd_t cmd
);
    import pih_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NORM, ST_DOT, ST_DOT_TAIL, ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [FACE_W-1:0] face_reg, face_next;
    logic              mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        face_next   = face_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        cmd.face    = face_reg;
        if (mvalid_reg && m_tready) mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    face_next = '0;
                    if (kind == KIND_LOAD) begin
                        cmd.load_vertex = 1'b1;
                        state_next = ST_NORM;
                    end else begin
                        cmd.latch_point = 1'b1;
                        cmd.clear_flag  = 1'b1;
                        state_next = ST_DOT;
                    end
                end
            end
            ST_NORM: begin
                cmd.norm_step = 1'b1;
                face_next = face_reg + 1'b1;
                if (face_reg == FACE_W'(NUM_FACES - 1)) state_next = ST_IDLE;
            end
            ST_DOT: begin
                cmd.dot_step = 1'b1;
                face_next = face_reg + 1'b1;
                if (face_reg == FACE_W'(NUM_FACES - 1)) state_next = ST_DOT_TAIL;
            end
            ST_DOT_TAIL: begin
                // last product settles into the flag
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            face_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            face_reg   <= face_next;
            mvalid_reg <= mvalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        face_reg <= FACE_W'(NUM_FACES - 1) || state_reg == ST_IDLE
        || state_reg == ST_DOT_TAIL || state_reg == ST_OUT) else $error("face out of range");
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.norm_step && cmd.dot_step)) else $error("two steps at once");
`endif
endmodule

// ===== src/pih_dp.sv =====
// datapath for the point-in-hexahedron test unit
// corner store, normal store, cross-product and dot-product units shared across faces; depends on pih_pkg
module pih_dp #(
    parameter int COORD_BITS = pih_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pih_pkg::pih_cmd_t         cmd,
    input  logic [2:0]                vertex_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                      inside_res
);
    import pih_pkg::*;

    localparam int DW = COORD_BITS + 1;        // difference
    localparam int NW = 2 * DW + 1;            // normal
    localparam int SW = NW + DW + 2;           // dot sum

    logic signed [COORD_BITS-1:0] vx_reg [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] vy_reg [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] vz_reg [NUM_CORNERS];
    logic signed [NW-1:0] nx_reg [NUM_FACES];
    logic signed [NW-1:0] ny_reg [NUM_FACES];
    logic signed [NW-1:0] nz_reg [NUM_FACES];
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [SW-1:0] dot_reg;
    logic dot_vld_reg, inside_reg, res_reg;

    logic [CORNER_W-1:0] ci, ai, bi;
    logic signed [DW-1:0] ax, ay, az, bx, by, bz, dx, dy, dz;
    logic signed [NW-1:0] cx, cy, cz;
    logic signed [SW-1:0] dot_next;

    assign ci = face_core(cmd.face);
    assign ai = face_a(cmd.face);
    assign bi = face_b(cmd.face);

    always_comb begin
        ax = DW'(vx_reg[ai]) - DW'(vx_reg[ci]);
        ay = DW'(vy_reg[ai]) - DW'(vy_reg[ci]);
        az = DW'(vz_reg[ai]) - DW'(vz_reg[ci]);
        bx = DW'(vx_reg[bi]) - DW'(vx_reg[ci]);
        by = DW'(vy_reg[bi]) - DW'(vy_reg[ci]);
        bz = DW'(vz_reg[bi]) - DW'(vz_reg[ci]);
        dx = DW'(px_reg) - DW'(vx_reg[ci]);
        dy = DW'(py_reg) - DW'(vy_reg[ci]);
        dz = DW'(pz_reg) - DW'(vz_reg[ci]);
        cx = NW'(ay) * NW'(bz) - NW'(az) * NW'(by);
        cy = NW'(az) * NW'(bx) - NW'(ax) * NW'(bz);
        cz = NW'(ax) * NW'(by) - NW'(ay) * NW'(bx);
        dot_next = SW'(nx_reg[cmd.face]) * SW'(dx) + SW'(ny_reg[cmd.face]) * SW'(dy)
                 + SW'(nz_reg[cmd.face]) * SW'(dz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                vx_reg[i] <= '0; vy_reg[i] <= '0; vz_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_FACES; i++) begin
                nx_reg[i] <= '0; ny_reg[i] <= '0; nz_reg[i] <= '0;
            end
            dot_vld_reg <= 1'b0;
            inside_reg  <= 1'b1;
            res_reg     <= 1'b0;
        end else begin
            if (cmd.load_vertex) begin
                vx_reg[vertex_index] <= coord_x;
                vy_reg[vertex_index] <= coord_y;
                vz_reg[vertex_index] <= coord_z;
            end
            if (cmd.norm_step) begin
                nx_reg[cmd.face] <= cx;
                ny_reg[cmd.face] <= cy;
                nz_reg[cmd.face] <= cz;
            end
            dot_vld_reg <= cmd.dot_step;
            if (cmd.clear_flag) inside_reg <= 1'b1;
            else if (dot_vld_reg && dot_reg[SW-1]) inside_reg <= 1'b0;
            if (cmd.load_result) res_reg <= inside_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_point) begin
            px_reg <= coord_x; py_reg <= coord_y; pz_reg <= coord_z;
        end
        dot_reg <= dot_next;
    end

    assign inside_res = res_reg;
endmodule
